// File: design/rtp_header_rewriter_macros.svh
// Assertion macros for the RTP header rewriter checker.
`ifndef RTP_HEADER_REWRITER_MACROS_SVH
`define RTP_HEADER_REWRITER_MACROS_SVH

// same-cycle implication
`define RTPHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtphr: property failed");

// next-cycle implication
`define RTPHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtphr: property failed");

// delayed implication: |=> followed by a further ##1
`define RTPHR_ASSERT_NXT2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("rtphr: property failed");

`endif

// File: design/rtphr_pkg.sv
`default_nettype none

package rtphr_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_SEQ_ENABLE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SEQ_START    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TS_ENABLE    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TS_START     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TS_INCREMENT = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SSRC_ENABLE  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SSRC_VALUE   = 3'd6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam int FifoDepth = 2;
    localparam int FifoPtrW  = 1;
    localparam int FifoCntW  = 2;

    typedef struct packed {
        logic        seq_enable;
        logic [15:0] seq_start;
        logic        ts_enable;
        logic [31:0] ts_start;
        logic [31:0] ts_increment;
        logic        ssrc_enable;
        logic [31:0] ssrc_value;
    } cfg_t;

    // one classified header on its way to the back end
    typedef struct packed {
        logic        seq_rw;
        logic        ts_rw;
        logic        ssrc_rw;
        logic [15:0] old_checksum;
        logic [15:0] old_seq;
        logic [31:0] old_timestamp;
        logic [31:0] old_ssrc;
        logic [15:0] rep_seq;
        logic [31:0] rep_timestamp;
        logic [31:0] rep_ssrc;
    } job_t;

endpackage

`default_nettype wire

// File: design/rtphr_hdr_if.sv
`default_nettype none

interface rtphr_hdr_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ip_protocol;
    logic [15:0] old_checksum;
    logic [15:0] old_seq;
    logic [31:0] old_timestamp;
    logic [31:0] old_ssrc;

    modport source (
        output valid, ip_protocol, old_checksum, old_seq, old_timestamp, old_ssrc,
        input  ready
    );
    modport sink (
        input  valid, ip_protocol, old_checksum, old_seq, old_timestamp, old_ssrc,
        output ready
    );
endinterface

`default_nettype wire

// File: design/rtphr_upd_if.sv
`default_nettype none

interface rtphr_upd_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_checksum;
    logic [15:0] new_seq;
    logic [31:0] new_timestamp;
    logic [31:0] new_ssrc;

    modport source (
        output valid, new_checksum, new_seq, new_timestamp, new_ssrc,
        input  ready
    );
    modport sink (
        input  valid, new_checksum, new_seq, new_timestamp, new_ssrc,
        output ready
    );
endinterface

`default_nettype wire

// File: design/rtp_header_rewriter.sv
// A header word accepted here is written into the queue, and its result word is registered
// in the output register once the back end takes it from the queue.
// Throughput: one word per cycle unless the queue is full or the output stalls; the front
// counters and the back checksum adder each end in a register, and a two-entry queue between
// them lets either side stall alone. Ready drops only while that queue is full.
// Reset clears the registers to zero, the counters and the started flag, and empties the
// queue and the output register.
`default_nettype none

module rtp_header_rewriter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rtphr_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rtphr_pkg::CfgDataW-1:0] cfg_data,
    rtphr_hdr_if.sink                           hdr,
    rtphr_upd_if.source                         upd
);

    rtphr_pkg::cfg_t cfg;
    rtphr_pkg::job_t push_job;
    rtphr_pkg::job_t pop_job;
    logic            push;
    logic            full;
    logic            pop;
    logic            empty;

    rtphr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtphr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .hdr   (hdr),
        .job   (push_job),
        .push  (push),
        .full  (full)
    );

    rtphr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_job),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (pop_job)
    );

    rtphr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (pop_job),
        .empty (empty),
        .pop   (pop),
        .upd   (upd)
    );

endmodule

`default_nettype wire

// File: design/rtphr_cfg.sv
`default_nettype none

module rtphr_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rtphr_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rtphr_pkg::CfgDataW-1:0] cfg_data,
    output rtphr_pkg::cfg_t                     cfg
);

    rtphr_pkg::cfg_t cfg_reg;
    rtphr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rtphr_pkg::REG_SEQ_ENABLE:   cfg_next.seq_enable   = cfg_data[0];
                rtphr_pkg::REG_SEQ_START:    cfg_next.seq_start    = cfg_data[15:0];
                rtphr_pkg::REG_TS_ENABLE:    cfg_next.ts_enable    = cfg_data[0];
                rtphr_pkg::REG_TS_START:     cfg_next.ts_start     = cfg_data[31:0];
                rtphr_pkg::REG_TS_INCREMENT: cfg_next.ts_increment = cfg_data[31:0];
                rtphr_pkg::REG_SSRC_ENABLE:  cfg_next.ssrc_enable  = cfg_data[0];
                rtphr_pkg::REG_SSRC_VALUE:   cfg_next.ssrc_value   = cfg_data[31:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/rtphr_front.sv
`default_nettype none

module rtphr_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  rtphr_pkg::cfg_t cfg,
    rtphr_hdr_if.sink       hdr,
    output rtphr_pkg::job_t job,
    output logic            push,
    input  wire logic       full
);

    logic        started_reg;
    logic        started_next;
    logic [15:0] seq_cnt_reg;
    logic [15:0] seq_cnt_next;
    logic [31:0] ts_cnt_reg;
    logic [31:0] ts_cnt_next;

    logic        is_rtp;
    logic [15:0] cur_seq;
    logic [31:0] cur_ts;

    assign hdr.ready = !full;
    assign push      = hdr.valid && !full;

    assign is_rtp  = (hdr.ip_protocol == rtphr_pkg::PROTO_TCP) ||
                     (hdr.ip_protocol == rtphr_pkg::PROTO_UDP);
    // counters load their start values on the first TCP/UDP packet
    assign cur_seq = started_reg ? seq_cnt_reg : cfg.seq_start;
    assign cur_ts  = started_reg ? ts_cnt_reg  : cfg.ts_start;

    always_comb
    begin
        job.seq_rw        = is_rtp && cfg.seq_enable;
        job.ts_rw         = is_rtp && cfg.ts_enable;
        job.ssrc_rw       = is_rtp && cfg.ssrc_enable;
        job.old_checksum  = hdr.old_checksum;
        job.old_seq       = hdr.old_seq;
        job.old_timestamp = hdr.old_timestamp;
        job.old_ssrc      = hdr.old_ssrc;
        job.rep_seq       = cur_seq;
        job.rep_timestamp = cur_ts;
        job.rep_ssrc      = cfg.ssrc_value;
    end

    always_comb
    begin
        started_next = started_reg;
        seq_cnt_next = seq_cnt_reg;
        ts_cnt_next  = ts_cnt_reg;
        if (push && is_rtp)
        begin
            started_next = 1'b1;
            if (cfg.seq_enable)
            begin
                seq_cnt_next = cur_seq + 16'd1;
            end
            if (cfg.ts_enable)
            begin
                ts_cnt_next = cur_ts + cfg.ts_increment;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            seq_cnt_reg <= '0;
            ts_cnt_reg  <= '0;
        end
        else
        begin
            started_reg <= started_next;
            seq_cnt_reg <= seq_cnt_next;
            ts_cnt_reg  <= ts_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rtphr_fifo.sv
`default_nettype none

module rtphr_fifo (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  rtphr_pkg::job_t wr_data,
    output logic            full,
    input  wire logic       pop,
    output logic            empty,
    output rtphr_pkg::job_t rd_data
);

    rtphr_pkg::job_t mem_reg [rtphr_pkg::FifoDepth];

    logic [rtphr_pkg::FifoPtrW-1:0] wr_ptr_reg;
    logic [rtphr_pkg::FifoPtrW-1:0] wr_ptr_next;
    logic [rtphr_pkg::FifoPtrW-1:0] rd_ptr_reg;
    logic [rtphr_pkg::FifoPtrW-1:0] rd_ptr_next;
    logic [rtphr_pkg::FifoCntW-1:0] cnt_reg;
    logic [rtphr_pkg::FifoCntW-1:0] cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (cnt_reg == rtphr_pkg::FifoCntW'(rtphr_pkg::FifoDepth));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rtphr_back.sv
`default_nettype none

module rtphr_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  rtphr_pkg::job_t job,
    input  wire logic       empty,
    output logic            pop,
    rtphr_upd_if.source     upd
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] ck_reg;
    logic [15:0] seq_reg;
    logic [31:0] ts_reg;
    logic [31:0] ssrc_reg;

    logic [19:0] t_seq;
    logic [19:0] t_ts;
    logic [19:0] t_ssrc;
    logic [19:0] sum;
    logic [19:0] fold1;
    logic [15:0] fold2;
    logic [15:0] ck_new;

    assign pop = !empty && (!valid_reg || upd.ready);

    // RFC 1624 eqn 3 over all replaced words at once: one end-around sum
    always_comb
    begin
        t_seq  = job.seq_rw ?
                 ({4'b0, ~job.old_seq} + {4'b0, job.rep_seq}) : 20'd0;
        t_ts   = job.ts_rw ?
                 ({4'b0, ~job.old_timestamp[31:16]} + {4'b0, ~job.old_timestamp[15:0]} +
                  {4'b0, job.rep_timestamp[31:16]} + {4'b0, job.rep_timestamp[15:0]})
                 : 20'd0;
        t_ssrc = job.ssrc_rw ?
                 ({4'b0, ~job.old_ssrc[31:16]} + {4'b0, ~job.old_ssrc[15:0]} +
                  {4'b0, job.rep_ssrc[31:16]} + {4'b0, job.rep_ssrc[15:0]})
                 : 20'd0;
        sum    = {4'b0, ~job.old_checksum} + t_seq + t_ts + t_ssrc;
        fold1  = {4'b0, sum[15:0]} + {16'b0, sum[19:16]};
        fold2  = fold1[15:0] + {12'b0, fold1[19:16]};
        ck_new = ~fold2;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (upd.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ck_reg   <= ck_new;
            seq_reg  <= job.seq_rw  ? job.rep_seq       : job.old_seq;
            ts_reg   <= job.ts_rw   ? job.rep_timestamp : job.old_timestamp;
            ssrc_reg <= job.ssrc_rw ? job.rep_ssrc      : job.old_ssrc;
        end
    end

    assign upd.valid         = valid_reg;
    assign upd.new_checksum  = ck_reg;
    assign upd.new_seq       = seq_reg;
    assign upd.new_timestamp = ts_reg;
    assign upd.new_ssrc      = ssrc_reg;

endmodule

`default_nettype wire

// File: design/rtphr_checker.sv
`default_nettype none
`include "rtp_header_rewriter_macros.svh"

module rtphr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        hdr_valid,
    input wire logic        hdr_ready,
    input wire logic        upd_valid,
    input wire logic        upd_ready,
    input wire logic [15:0] new_checksum,
    input wire logic [15:0] new_seq,
    input wire logic [31:0] new_timestamp,
    input wire logic [31:0] new_ssrc
);

    logic        hdr_acc;
    logic        upd_acc;
    logic        upd_stall;
    logic [95:0] upd_word;
    logic [2:0]  pend_reg;
    logic [2:0]  pend_next;

    assign hdr_acc   = hdr_valid && hdr_ready;
    assign upd_acc   = upd_valid && upd_ready;
    assign upd_stall = upd_valid && !upd_ready;
    assign upd_word  = {new_checksum, new_seq, new_timestamp, new_ssrc};

    // words accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (hdr_acc && !upd_acc)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (upd_acc && !hdr_acc)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `RTPHR_ASSERT_NXT(a_out_hold, clk, rst_n, upd_stall, upd_valid && $stable(upd_word))
    `RTPHR_ASSERT_IMP(a_no_phantom, clk, rst_n, upd_valid, pend_reg != 3'd0)
    `RTPHR_ASSERT_IMP(a_bounded, clk, rst_n, 1'b1, pend_reg <= 3'd3)
    `RTPHR_ASSERT_NXT2(a_latency, clk, rst_n, hdr_acc && pend_reg == 3'd0, upd_valid)

endmodule

bind rtp_header_rewriter rtphr_checker u_rtphr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .hdr_valid     (hdr.valid),
    .hdr_ready     (hdr.ready),
    .upd_valid     (upd.valid),
    .upd_ready     (upd.ready),
    .new_checksum  (upd.new_checksum),
    .new_seq       (upd.new_seq),
    .new_timestamp (upd.new_timestamp),
    .new_ssrc      (upd.new_ssrc)
);

`default_nettype wire
